>>> rtl/pus_pkg.sv
// Shared types, constants and the Paeth predictor for the PNG scanline unfilter.
package pus_pkg;

    // Default sizes for the top-level parameters
    localparam int DEF_MAX_LINE_BYTES  = 4096;
    localparam int DEF_MAX_PIXEL_BYTES = 8;

    // Depth of the queue between the front and back parts
    localparam int QUEUE_DEPTH = 4;

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 13;
    localparam logic [CFG_IDX_W-1:0] CFG_BYTES_PER_PIXEL = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_BYTES      = 1'd1;

    // Register reset values
    localparam logic [3:0]            BPP_RESET  = 4'd4;
    localparam logic [CFG_DATA_W-1:0] LINE_RESET = 13'd1024;

    typedef logic [7:0] t_byte;

    // Row filter codes
    typedef enum logic [2:0] {
        FLT_NONE  = 3'd0,
        FLT_SUB   = 3'd1,
        FLT_UP    = 3'd2,
        FLT_AVG   = 3'd3,
        FLT_PAETH = 3'd4
    } t_filter;

    // Input request payload
    typedef struct packed {
        t_byte in_byte;
        logic  image_start;
    } t_in_item;

    // Output request payload
    typedef struct packed {
        t_byte out_byte;
        logic  line_end;
        logic  filter_error;
    } t_out_item;

    // Classified work handed from front to back
    typedef struct packed {
        logic    is_error;
        t_filter filter;
        logic    first_row;
        logic    row_start;
        logic    line_end;
        t_byte   value;
    } t_work;

    // Paeth predictor: pick the neighbor closest to a + b - c
    function automatic t_byte paeth(input t_byte a, input t_byte b, input t_byte c);
        logic signed [10:0] da;
        logic signed [10:0] db;
        logic signed [10:0] dc;
        logic        [10:0] pa;
        logic        [10:0] pb;
        logic        [10:0] pc;
        t_byte              res;
        da = $signed({3'b000, b}) - $signed({3'b000, c});
        db = $signed({3'b000, a}) - $signed({3'b000, c});
        dc = da + db;
        pa = da[10] ? 11'(-da) : 11'(da);
        pb = db[10] ? 11'(-db) : 11'(db);
        pc = dc[10] ? 11'(-dc) : 11'(dc);
        if (pa <= pb && pa <= pc) begin
            res = a;
        end else if (pb <= pc) begin
            res = b;
        end else begin
            res = c;
        end
        return res;
    endfunction

endpackage

>>> rtl/pus_in_if.sv
// Input stream channel: valid/ready handshake with one filtered byte per request.
interface pus_in_if;
    import pus_pkg::*;

    logic     valid;
    logic     ready;
    t_in_item payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

>>> rtl/pus_out_if.sv
// Output stream channel: valid/ready handshake with one rebuilt byte per request.
interface pus_out_if;
    import pus_pkg::*;

    logic      valid;
    logic      ready;
    t_out_item payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

>>> rtl/pus_front.sv
// Front part: accepts stream bytes, tracks row position and filter, classifies each byte.
module pus_front import pus_pkg::*; #(
    parameter int MAX_LINE_BYTES = DEF_MAX_LINE_BYTES,
    localparam int POS_W = (MAX_LINE_BYTES > 1) ? $clog2(MAX_LINE_BYTES) : 1,
    localparam int LEN_W = $clog2(MAX_LINE_BYTES + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    pus_in_if.sink           i_in,
    input  logic [LEN_W-1:0] i_line_len,
    input  logic             i_q_full,
    output logic             o_push,
    output t_work            o_push_work,
    output logic [POS_W-1:0] o_push_pos
);

    logic [POS_W-1:0] r_pos, n_pos;
    t_filter          r_filter, n_filter;
    logic             r_expect, n_expect;
    logic             r_first, n_first;
    logic             r_err, n_err;

    logic             accept;
    logic             start;
    logic [POS_W-1:0] s_pos;
    logic             s_expect;
    logic             s_first;
    logic             s_err;
    logic             bad_code;
    logic             last_byte;

    // Take a request whenever the queue has room
    assign i_in.ready = !i_q_full;
    assign accept     = i_in.valid && !i_q_full;
    assign start      = i_in.payload.image_start;

    // Row state as seen after an image start
    assign s_pos    = start ? '0 : r_pos;
    assign s_expect = start || r_expect;
    assign s_first  = start || r_first;
    assign s_err    = !start && r_err;

    assign bad_code  = i_in.payload.in_byte > t_byte'(FLT_PAETH);
    assign last_byte = (LEN_W'(s_pos) + LEN_W'(1)) >= i_line_len;

    // Classify the byte and build the work entry
    always_comb begin
        o_push                = 1'b0;
        o_push_pos            = s_pos;
        o_push_work.is_error  = 1'b0;
        o_push_work.filter    = r_filter;
        o_push_work.first_row = s_first;
        o_push_work.row_start = (s_pos == '0);
        o_push_work.line_end  = last_byte;
        o_push_work.value     = i_in.payload.in_byte;
        if (accept && !s_err) begin
            if (s_expect) begin
                if (bad_code) begin
                    o_push               = 1'b1;
                    o_push_work.is_error = 1'b1;
                end
            end else begin
                o_push = 1'b1;
            end
        end
    end

    // Advance the row state
    always_comb begin
        n_pos    = r_pos;
        n_filter = r_filter;
        n_expect = r_expect;
        n_first  = r_first;
        n_err    = r_err;
        if (accept) begin
            n_pos    = s_pos;
            n_expect = s_expect;
            n_first  = s_first;
            n_err    = s_err;
            if (!s_err) begin
                if (s_expect) begin
                    if (bad_code) begin
                        n_err = 1'b1;
                    end else begin
                        n_filter = t_filter'(i_in.payload.in_byte[2:0]);
                        n_expect = 1'b0;
                        n_pos    = '0;
                    end
                end else if (last_byte) begin
                    n_pos    = '0;
                    n_expect = 1'b1;
                    n_first  = 1'b0;
                end else begin
                    n_pos = s_pos + POS_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_filter <= FLT_NONE;
            r_expect <= 1'b1;
            r_first  <= 1'b1;
            r_err    <= 1'b0;
        end else begin
            r_pos    <= n_pos;
            r_filter <= n_filter;
            r_expect <= n_expect;
            r_first  <= n_first;
            r_err    <= n_err;
        end
    end

endmodule

>>> rtl/pus_queue.sv
// Short FIFO that decouples the front and back parts.
module pus_queue import pus_pkg::*; #(
    parameter int WIDTH = 16,
    parameter int DEPTH = QUEUE_DEPTH,
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_push_data,
    output logic             o_full,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_head,
    input  logic             i_pop
);

    logic [WIDTH-1:0] r_slot [DEPTH];
    logic [PTR_W-1:0] r_wr, n_wr;
    logic [PTR_W-1:0] r_rd, n_rd;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_head  = r_slot[r_rd];

    // Advance pointers and fill count
    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wr = (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
        end
        if (i_pop) begin
            n_rd = (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + CNT_W'(1);
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    // Store the pushed entry
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr] <= i_push_data;
        end
    end

endmodule

>>> rtl/pus_back.sv
// Back part: reads the row above, rebuilds each byte and drives the output register.
module pus_back import pus_pkg::*; #(
    parameter int MAX_LINE_BYTES  = DEF_MAX_LINE_BYTES,
    parameter int MAX_PIXEL_BYTES = DEF_MAX_PIXEL_BYTES,
    localparam int POS_W = (MAX_LINE_BYTES > 1) ? $clog2(MAX_LINE_BYTES) : 1,
    localparam int SEL_W = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_valid,
    input  t_work            i_q_work,
    input  logic [POS_W-1:0] i_q_pos,
    output logic             o_pop,
    input  logic [SEL_W-1:0] i_left_sel,
    pus_out_if.source        o_out
);

    // Row memory: previous row, one byte per position
    t_byte            r_mem [MAX_LINE_BYTES];

    // Reconstruction stage
    logic             r_s1_valid;
    t_work            r_s1_work;
    logic [POS_W-1:0] r_s1_pos;
    t_byte            r_s1_rd;
    logic             r_s1_fwd;
    t_byte            r_s1_fwd_val;

    // Left and upper-left byte history
    t_byte            r_left [MAX_PIXEL_BYTES];
    t_byte            r_upleft [MAX_PIXEL_BYTES];
    t_byte            eff_left [MAX_PIXEL_BYTES];
    t_byte            eff_upleft [MAX_PIXEL_BYTES];

    // Output register
    logic             r_out_valid;
    t_out_item        r_out;

    logic             adv;
    logic             s1_write;
    t_byte            a_val;
    t_byte            b_val;
    t_byte            c_val;
    t_byte            pred;
    t_byte            rec;
    logic [8:0]       avg_sum;

    assign adv      = r_s1_valid && (!r_out_valid || o_out.ready);
    assign o_pop    = i_q_valid && (!r_s1_valid || adv);
    assign s1_write = adv && !r_s1_work.is_error;

    // Neighbors: history reads as zero at the start of a row, row above on the first row
    always_comb begin
        for (int i = 0; i < MAX_PIXEL_BYTES; i++) begin
            eff_left[i]   = r_s1_work.row_start ? '0 : r_left[i];
            eff_upleft[i] = r_s1_work.row_start ? '0 : r_upleft[i];
        end
    end

    assign a_val   = eff_left[i_left_sel];
    assign c_val   = eff_upleft[i_left_sel];
    assign b_val   = r_s1_work.first_row ? '0 : (r_s1_fwd ? r_s1_fwd_val : r_s1_rd);
    assign avg_sum = {1'b0, a_val} + {1'b0, b_val};

    // Predict from the row filter
    always_comb begin
        unique case (r_s1_work.filter)
            FLT_NONE:  pred = '0;
            FLT_SUB:   pred = a_val;
            FLT_UP:    pred = b_val;
            FLT_AVG:   pred = avg_sum[8:1];
            FLT_PAETH: pred = paeth(a_val, b_val, c_val);
            default:   pred = '0;
        endcase
    end

    assign rec = r_s1_work.value + pred;

    // Load the stage on pop; forward a byte written to the same position this cycle
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_s1_work    <= i_q_work;
            r_s1_pos     <= i_q_pos;
            r_s1_fwd     <= s1_write && (r_s1_pos == i_q_pos);
            r_s1_fwd_val <= rec;
        end
    end

    // Read the row above on pop
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_s1_rd <= r_mem[i_q_pos];
        end
    end

    // Write the rebuilt byte back for the next row
    always_ff @(posedge i_clk) begin
        if (s1_write) begin
            r_mem[r_s1_pos] <= rec;
        end
    end

    // Shift the byte history
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_PIXEL_BYTES; i++) begin
                r_left[i]   <= '0;
                r_upleft[i] <= '0;
            end
        end else if (s1_write) begin
            r_left[0]   <= rec;
            r_upleft[0] <= b_val;
            for (int i = 1; i < MAX_PIXEL_BYTES; i++) begin
                r_left[i]   <= eff_left[i-1];
                r_upleft[i] <= eff_upleft[i-1];
            end
        end
    end

    // Stage and output valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_s1_valid <= 1'b1;
            end else if (adv) begin
                r_s1_valid <= 1'b0;
            end
            if (adv) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Hold the result until the sink takes it
    always_ff @(posedge i_clk) begin
        if (adv) begin
            if (r_s1_work.is_error) begin
                r_out.out_byte     <= '0;
                r_out.line_end     <= 1'b0;
                r_out.filter_error <= 1'b1;
            end else begin
                r_out.out_byte     <= rec;
                r_out.line_end     <= r_s1_work.line_end;
                r_out.filter_error <= 1'b0;
            end
        end
    end

    assign o_out.valid   = r_out_valid;
    assign o_out.payload = r_out;

endmodule

>>> rtl/png_scanline_unfilter_top.sv
// PNG scanline unfilter top level: configuration registers, front, queue and back.
//
// Rebuilds PNG filtered scanlines (none, sub, up, average, Paeth) from the inflated
// byte stream, one byte per request. The first byte of each row is its filter code
// and gives no result; each data byte gives one result, flagged line_end on the last
// byte of its row. A code above 4 gives one error result, then bytes are dropped up
// to the next image_start. Throughput is one byte per clock once the pipeline is full
// and the sink is ready; a byte passes through the queue, the reconstruction stage and
// the output register. The cycle is set by the reconstruction stage, where the
// left-neighbor feedback runs through the Paeth compare and the final add. The row
// memory has one read port (on queue pop) and one write port (on reconstruction),
// and needs no clearing after reset. Write bytes_per_pixel and line_bytes only while
// the block is idle; out-of-range values are clamped to the supported limits.
module png_scanline_unfilter_top import pus_pkg::*; #(
    parameter int MAX_LINE_BYTES  = DEF_MAX_LINE_BYTES,
    parameter int MAX_PIXEL_BYTES = DEF_MAX_PIXEL_BYTES
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    pus_in_if.sink                i_in,
    pus_out_if.source             o_out
);

    localparam int POS_W = (MAX_LINE_BYTES > 1) ? $clog2(MAX_LINE_BYTES) : 1;
    localparam int LEN_W = $clog2(MAX_LINE_BYTES + 1);
    localparam int SEL_W = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;
    localparam int CMP_W = (LEN_W > CFG_DATA_W) ? LEN_W : CFG_DATA_W;
    localparam int Q_W   = $bits(t_work) + POS_W;

    logic [3:0]            r_bpp;
    logic [CFG_DATA_W-1:0] r_line;

    logic [3:0]            bpp_eff;
    logic [LEN_W-1:0]      line_len;
    logic [SEL_W-1:0]      left_sel;

    logic                  push;
    t_work                 push_work;
    logic [POS_W-1:0]      push_pos;
    logic                  q_full;
    logic                  q_valid;
    logic [Q_W-1:0]        q_head;
    logic                  pop;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bpp  <= BPP_RESET;
            r_line <= LINE_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_BYTES_PER_PIXEL: r_bpp  <= i_cfg_wdata[3:0];
                CFG_LINE_BYTES:      r_line <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Clamp pixel size and row length to the supported range
    always_comb begin
        if (r_bpp == '0) begin
            bpp_eff = 4'd1;
        end else if (r_bpp > 4'(MAX_PIXEL_BYTES)) begin
            bpp_eff = 4'(MAX_PIXEL_BYTES);
        end else begin
            bpp_eff = r_bpp;
        end
        if (r_line == '0) begin
            line_len = LEN_W'(1);
        end else if (CMP_W'(r_line) > CMP_W'(MAX_LINE_BYTES)) begin
            line_len = LEN_W'(MAX_LINE_BYTES);
        end else begin
            line_len = LEN_W'(r_line);
        end
    end

    assign left_sel = SEL_W'(bpp_eff - 4'd1);

    pus_front #(
        .MAX_LINE_BYTES (MAX_LINE_BYTES)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_line_len  (line_len),
        .i_q_full    (q_full),
        .o_push      (push),
        .o_push_work (push_work),
        .o_push_pos  (push_pos)
    );

    pus_queue #(
        .WIDTH (Q_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data ({push_pos, push_work}),
        .o_full      (q_full),
        .o_valid     (q_valid),
        .o_head      (q_head),
        .i_pop       (pop)
    );

    pus_back #(
        .MAX_LINE_BYTES  (MAX_LINE_BYTES),
        .MAX_PIXEL_BYTES (MAX_PIXEL_BYTES)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (q_valid),
        .i_q_work   (t_work'(q_head[$bits(t_work)-1:0])),
        .i_q_pos    (q_head[Q_W-1:$bits(t_work)]),
        .o_pop      (pop),
        .i_left_sel (left_sel),
        .o_out      (o_out)
    );

endmodule

>>> tb/scanline_check_pkg.sv
// Scoreboard for the PNG scanline unfilter: predicts rebuilt bytes and checks each result.
package scanline_check_pkg;
    import pus_pkg::*;

    localparam int REPORT_LIMIT = 10;

    class scanline_scoreboard;
        // Format registers as last written
        logic [3:0]            bpp_reg = BPP_RESET;
        logic [CFG_DATA_W-1:0] len_reg = LINE_RESET;

        // Row state of the unfilter
        t_byte       row_above [DEF_MAX_LINE_BYTES];
        logic [63:0] left_hist   = '0;
        logic [63:0] upleft_hist = '0;
        int unsigned pos         = 0;
        t_filter     filt        = FLT_NONE;
        bit          want_code   = 1'b1;
        bit          top_row     = 1'b1;
        bit          dropping    = 1'b0;

        // Count of row memory positions written since reset, from position 0 up
        int unsigned span = 0;

        t_out_item rebuilt_q [$];
        int        bad_results = 0;

        function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                CFG_BYTES_PER_PIXEL: bpp_reg = value[3:0];
                CFG_LINE_BYTES:      len_reg = value;
                default:             ;
            endcase
        endfunction

        // Clamp the pixel size to the supported range
        function int unsigned pixel_bytes();
            if (bpp_reg == 0) return 1;
            if (bpp_reg > DEF_MAX_PIXEL_BYTES) return DEF_MAX_PIXEL_BYTES;
            return int'(bpp_reg);
        endfunction

        // Clamp the row length to the supported range
        function int unsigned row_length();
            if (len_reg == 0) return 1;
            if (len_reg > DEF_MAX_LINE_BYTES) return DEF_MAX_LINE_BYTES;
            return int'(len_reg);
        endfunction

        // Pick the neighbor nearest to left + above - upper left
        function t_byte paeth_pick(t_byte a, t_byte b, t_byte c);
            int est, da, db, dc;
            est = int'(a) + int'(b) - int'(c);
            da = est - int'(a);
            db = est - int'(b);
            dc = est - int'(c);
            if (da < 0) da = -da;
            if (db < 0) db = -db;
            if (dc < 0) dc = -dc;
            if (da <= db && da <= dc) return a;
            if (db <= dc) return b;
            return c;
        endfunction

        // Advance the row state by one accepted request; return 1 when it is dropped
        function bit note_byte(t_in_item item);
            t_byte     a, b, c, pred, rec;
            t_out_item res;
            if (item.image_start) begin
                pos         = 0;
                left_hist   = '0;
                upleft_hist = '0;
                want_code   = 1'b1;
                top_row     = 1'b1;
                dropping    = 1'b0;
            end
            if (dropping) return 1'b1;

            // Filter code byte: no result unless the code is bad
            if (want_code) begin
                if (item.in_byte > t_byte'(FLT_PAETH)) begin
                    dropping         = 1'b1;
                    res.out_byte     = '0;
                    res.line_end     = 1'b0;
                    res.filter_error = 1'b1;
                    rebuilt_q.push_back(res);
                    return 1'b0;
                end
                filt        = t_filter'(item.in_byte[2:0]);
                want_code   = 1'b0;
                pos         = 0;
                left_hist   = '0;
                upleft_hist = '0;
                return 1'b0;
            end

            // Data byte: rebuild from left, above and upper-left neighbors
            a = t_byte'(left_hist >> (8 * (pixel_bytes() - 1)));
            c = t_byte'(upleft_hist >> (8 * (pixel_bytes() - 1)));
            b = top_row ? t_byte'(0) : row_above[pos];
            case (filt)
                FLT_SUB:   pred = a;
                FLT_UP:    pred = b;
                FLT_AVG:   pred = t_byte'((int'(a) + int'(b)) >> 1);
                FLT_PAETH: pred = paeth_pick(a, b, c);
                default:   pred = '0;
            endcase
            rec = item.in_byte + pred;

            row_above[pos] = rec;
            if (pos + 1 > span) span = pos + 1;
            left_hist   = {left_hist[55:0], rec};
            upleft_hist = {upleft_hist[55:0], b};

            res.out_byte     = rec;
            res.filter_error = 1'b0;
            if (pos + 1 >= row_length()) begin
                res.line_end = 1'b1;
                pos          = 0;
                want_code    = 1'b1;
                top_row      = 1'b0;
                left_hist    = '0;
                upleft_hist  = '0;
            end else begin
                res.line_end = 1'b0;
                pos++;
            end
            rebuilt_q.push_back(res);
            return 1'b0;
        endfunction

        // Compare one accepted result with the oldest prediction
        function void check_rebuilt(t_out_item got);
            t_out_item want;
            if (rebuilt_q.size() == 0) begin
                bad_results++;
                if (bad_results <= REPORT_LIMIT)
                    $display("%0t: unexpected result: byte %02h end %b err %b",
                             $time, got.out_byte, got.line_end, got.filter_error);
                return;
            end
            want = rebuilt_q.pop_front();
            if (got.out_byte !== want.out_byte || got.line_end !== want.line_end
                    || got.filter_error !== want.filter_error) begin
                bad_results++;
                if (bad_results <= REPORT_LIMIT) begin
                    $write("%0t: rebuilt byte differs: expected byte %02h end %b err %b,",
                           $time, want.out_byte, want.line_end, want.filter_error);
                    $display(" got byte %02h end %b err %b",
                             got.out_byte, got.line_end, got.filter_error);
                end
            end
        endfunction

        function int pending();
            return rebuilt_q.size();
        endfunction

        function int failures();
            return bad_results + rebuilt_q.size();
        endfunction
    endclass

endpackage

>>> tb/tb.sv
// Testbench top: drives filtered PNG byte streams into the unfilter and checks rebuilt bytes.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pus_pkg::*;
    import scanline_check_pkg::*;

    localparam int DRAIN_CYCLES   = 8;
    localparam int RANDOM_PHASES  = 12;
    localparam int PHASE_ITEMS    = 56;
    localparam int WIDE_ROW_BYTES = 48;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_wdata;

    pus_in_if  in_ch ();
    pus_out_if out_ch ();

    scanline_scoreboard sb;

    int src_gap_max   = 13;
    int snk_stall_max = 13;
    bit start_due     = 1'b0;

    png_scanline_unfilter_top i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (in_ch),
        .o_out       (out_ch)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Choose between back-to-back, light and heavy idling
    function automatic int pick_wait_limit();
        case ($urandom_range(0, 2))
            0:       return 0;
            1:       return 3;
            default: return 13;
        endcase
    endfunction

    // Filter code, now and then a bad one
    function automatic t_byte pick_code();
        case ($urandom_range(0, 39))
            0:       return t_byte'($urandom_range(FLT_PAETH + 1, 7));
            1:       return t_byte'($urandom_range(8, 255));
            default: return t_byte'($urandom_range(FLT_NONE, FLT_PAETH));
        endcase
    endfunction

    // Data byte, weighted toward the extremes
    function automatic t_byte pick_data();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return t_byte'($urandom_range(0, 255));
        endcase
    endfunction

    // Present one request after a random gap and hold it until accepted
    task automatic send_item(input t_byte value, input logic start, output bit ignored);
        int       gap;
        bit       hold;
        t_in_item item;
        item.in_byte     = value;
        item.image_start = start;
        if ($urandom_range(0, 39) == 0) src_gap_max = pick_wait_limit();
        gap  = $urandom_range(0, src_gap_max);
        hold = ($urandom_range(0, 59) == 0);
        if (hold && gap == 0) gap = 1;
        @(negedge i_clk);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            while (hold && sb.pending() != 0) @(negedge i_clk);
            repeat (gap) @(negedge i_clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.payload <= item;
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
        ignored = sb.note_byte(item);
    endtask

    // Send a filter code and a row of random data bytes
    task automatic send_row(input t_byte code, input logic start, input int count);
        bit ignored;
        send_item(code, start || start_due, ignored);
        start_due = 1'b0;
        repeat (count) send_item(pick_data(), 1'b0, ignored);
    endtask

    // Drop valid and wait until the block has nothing left in flight
    task automatic settle();
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        sb.write_register(idx, value);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Change the format while idle; a row longer than the written memory needs a new image
    task automatic set_format(input int bpp, input int len);
        settle();
        write_reg(CFG_BYTES_PER_PIXEL, CFG_DATA_W'(bpp));
        write_reg(CFG_LINE_BYTES, CFG_DATA_W'(len));
        if (sb.row_length() > sb.span) start_due = 1'b1;
    endtask

    // Mostly well-formed images with random content, plus stray starts and dropped bytes
    task automatic random_traffic(input int budget);
        int    used;
        bit    ignored;
        bit    start;
        t_byte value;
        used = 0;
        while (used < budget) begin
            start = start_due || (sb.dropping && $urandom_range(0, 3) == 0)
                    || $urandom_range(0, 149) == 0;
            if (sb.dropping && !start) begin
                value = t_byte'($urandom_range(0, 255));
            end else if (start || sb.want_code) begin
                value = pick_code();
            end else begin
                value = pick_data();
            end
            send_item(value, start, ignored);
            if (start) start_due = 1'b0;
            if (!ignored) used++;
        end
    endtask

    // Stimulus
    initial begin
        bit ignored;
        sb = new;
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = '0;
        i_cfg_wdata   = '0;
        in_ch.valid   = 1'b0;
        in_ch.payload = '0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Stream with no image start after reset, at the reset format
        send_row(FLT_SUB, 1'b0, 2);

        // One row of each filter, one-byte pixels
        set_format(1, 3);
        send_row(FLT_NONE, 1'b1, 3);
        send_row(FLT_SUB, 1'b0, 3);
        send_row(FLT_UP, 1'b0, 3);
        send_row(FLT_AVG, 1'b0, 3);
        send_row(FLT_PAETH, 1'b0, 3);

        // Bad codes: one error result, then drop until the next image start
        send_item(t_byte'(FLT_PAETH) + 8'd1, 1'b1, ignored);
        send_item(pick_data(), 1'b0, ignored);
        send_item(8'hFF, 1'b1, ignored);
        send_item(t_byte'(FLT_NONE), 1'b0, ignored);

        // Widest pixels, two full rows
        set_format(DEF_MAX_PIXEL_BYTES, WIDE_ROW_BYTES);
        send_row(FLT_SUB, 1'b1, WIDE_ROW_BYTES);
        send_row(FLT_PAETH, 1'b0, WIDE_ROW_BYTES);

        // Saturating register values; stop partway through a row
        set_format(4'hF, 13'h1FFF);
        random_traffic(40);

        // Random formats; the first shrinks the row in progress
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            case (phase)
                0:       set_format(0, 0);
                1:       set_format(9, 2);
                2:       set_format(1, 1);
                3:       set_format(3, 17);
                default: set_format($urandom_range(1, 8), $urandom_range(1, 48));
            endcase
            random_traffic(PHASE_ITEMS);
        end

        settle();
        if (sb.failures() == 0) begin
            $display("png_scanline_unfilter_top: match");
        end else begin
            $display("png_scanline_unfilter_top: mismatch");
        end
        $finish;
    end

    // Result sink with random stalls
    initial begin
        int stall;
        int served;
        out_ch.ready = 1'b0;
        served       = 0;
        wait (i_rst_n === 1'b1);
        forever begin
            if (served % 32 == 0) snk_stall_max = pick_wait_limit();
            stall = $urandom_range(0, snk_stall_max);
            @(negedge i_clk);
            if (stall > 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (out_ch.valid !== 1'b1);
            sb.check_rebuilt(out_ch.payload);
            served++;
        end
    end

    // Hang guard
    initial begin
        #(20ms);
        $display("png_scanline_unfilter_top: mismatch");
        $finish;
    end

endmodule

>>> sim.f
rtl/pus_pkg.sv
rtl/pus_in_if.sv
rtl/pus_out_if.sv
rtl/pus_front.sv
rtl/pus_queue.sv
rtl/pus_back.sv
rtl/png_scanline_unfilter_top.sv
tb/scanline_check_pkg.sv
tb/tb.sv
